[rtl/i2cps_pkg.sv]
`timescale 1ns / 1ps

package i2cps_pkg;

  localparam int unsigned BIT_COUNT     = 8;
  localparam int unsigned BIT_IDX_W     = $clog2(BIT_COUNT);
  localparam int unsigned CMD_DEPTH_DEF = 2;
  localparam int unsigned RES_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SIG_DIR = 2'd0,
    SIG_SDA = 2'd1,
    SIG_SCL = 2'd2
  } sig_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PRE  = 2'd1,
    ST_LOOP = 2'd2,
    ST_POST = 2'd3
  } seq_state_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] station;
    logic [7:0] data_byte;
    logic       final_byte;
    logic [7:0] slave_bits;
  } in_t;

  typedef struct packed {
    logic [2:0] station_res;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       wait_after;
    logic [7:0] read_data;
    logic       last;
  } res_t;

  // Classified command handed from the front to the sequencer
  typedef struct packed {
    in_t        item;
    logic       has_loop;
    logic [2:0] pre_last;
    logic [1:0] post_last;
    logic [1:0] phase_last;
  } cmd_t;

  typedef struct packed {
    sig_e sig;
    logic val;
    logic wait_after;
    logic last;
  } ev_t;

endpackage

[rtl/i2cps_fifo.sv]
`timescale 1ns / 1ps

module i2cps_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  T                 regs_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = regs_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      regs_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/i2cps_front.sv]
`timescale 1ns / 1ps

module i2cps_front
  import i2cps_pkg::*;
(
  input  in_t  item_i,
  output cmd_t cmd_o
);

  // Sequence shape per op: prologue length, loop phases per bit, epilogue length
  always_comb begin
    cmd_o.item       = item_i;
    cmd_o.has_loop   = 1'b0;
    cmd_o.pre_last   = 3'd1;
    cmd_o.post_last  = 2'd0;
    cmd_o.phase_last = 2'd0;
    unique case (item_i.op)
      OP_START: begin
        cmd_o.pre_last = 3'd4;
      end
      OP_STOP: begin
        cmd_o.pre_last = 3'd5;
      end
      OP_WRITE: begin
        cmd_o.has_loop   = 1'b1;
        cmd_o.pre_last   = 3'd1;
        cmd_o.phase_last = 2'd2;
        cmd_o.post_last  = 2'd2;
      end
      OP_READ: begin
        cmd_o.has_loop   = 1'b1;
        cmd_o.pre_last   = 3'd1;
        cmd_o.phase_last = 2'd1;
        cmd_o.post_last  = 2'd3;
      end
      default: begin
        cmd_o.pre_last = 3'd1;
      end
    endcase
  end

endmodule

[rtl/i2cps_back.sv]
`timescale 1ns / 1ps

module i2cps_back
  import i2cps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  seq_state_e           state_q, state_d;
  cmd_t                 cur_q;
  logic [2:0]           step_q, step_d;
  logic [BIT_IDX_W-1:0] bit_q, bit_d;
  logic [1:0]           phase_q, phase_d;
  logic                 scl_q, scl_d;
  logic                 sda_q, sda_d;
  logic                 drv_q, drv_d;
  logic                 load;
  logic                 fire;
  logic                 pre_end, post_end, phase_end;
  ev_t                  ev;

  assign load      = (state_q == ST_IDLE) && cmd_valid_i;
  assign fire      = (state_q != ST_IDLE) && !res_full_i;
  assign cmd_pop_o = load;
  assign pre_end   = (step_q == cur_q.pre_last);
  assign post_end  = (step_q[1:0] == cur_q.post_last);
  assign phase_end = (phase_q == cur_q.phase_last);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) state_d = ST_PRE;
      end
      ST_PRE: begin
        if (fire && pre_end) state_d = cur_q.has_loop ? ST_LOOP : ST_IDLE;
      end
      ST_LOOP: begin
        if (fire && phase_end && (bit_q == BIT_IDX_W'(BIT_COUNT - 1))) state_d = ST_POST;
      end
      ST_POST: begin
        if (fire && post_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Step, bit and phase counters
  always_comb begin
    step_d  = step_q;
    bit_d   = bit_q;
    phase_d = phase_q;
    if (load) begin
      step_d  = '0;
      bit_d   = '0;
      phase_d = '0;
    end else if (fire) begin
      if (state_q == ST_LOOP) begin
        step_d = '0;
        if (phase_end) begin
          phase_d = '0;
          bit_d   = bit_q + 1'b1;
        end else begin
          phase_d = phase_q + 1'b1;
        end
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  // Event decode
  always_comb begin
    ev = '{sig: SIG_SCL, val: 1'b0, wait_after: 1'b0, last: 1'b0};
    unique case (state_q)
      ST_PRE: begin
        ev.last = pre_end && !cur_q.has_loop;
        unique case (cur_q.item.op)
          OP_START: begin
            unique case (step_q)
              3'd0:    ev = '{SIG_DIR, 1'b1, 1'b0, 1'b0};
              3'd1:    ev = '{SIG_SDA, 1'b1, 1'b0, 1'b0};
              3'd2:    ev = '{SIG_SCL, 1'b1, 1'b1, 1'b0};
              3'd3:    ev = '{SIG_SDA, 1'b0, 1'b0, 1'b0};
              default: ev = '{SIG_SCL, 1'b0, 1'b0, pre_end};
            endcase
          end
          OP_STOP: begin
            unique case (step_q)
              3'd0:    ev = '{SIG_DIR, 1'b1, 1'b0, 1'b0};
              3'd1:    ev = '{SIG_SDA, 1'b0, 1'b0, 1'b0};
              3'd2:    ev = '{SIG_SCL, 1'b1, 1'b1, 1'b0};
              3'd3:    ev = '{SIG_SDA, 1'b1, 1'b0, 1'b0};
              3'd4:    ev = '{SIG_SCL, 1'b0, 1'b1, 1'b0};
              default: ev = '{SIG_SCL, 1'b1, 1'b0, pre_end};
            endcase
          end
          OP_WRITE: begin
            if (step_q == 3'd0) ev = '{SIG_DIR, 1'b1, 1'b0, 1'b0};
            else                ev = '{SIG_SCL, 1'b0, 1'b0, 1'b0};
          end
          default: begin
            if (step_q == 3'd0) ev = '{SIG_DIR, 1'b0, 1'b0, 1'b0};
            else                ev = '{SIG_SCL, 1'b0, 1'b1, 1'b0};
          end
        endcase
      end
      ST_LOOP: begin
        if (cur_q.item.op == OP_WRITE) begin
          // MSB first: bit index n sends data_byte[7-n]
          unique case (phase_q)
            2'd0:    ev = '{SIG_SDA, cur_q.item.data_byte[~bit_q], 1'b1, 1'b0};
            2'd1:    ev = '{SIG_SCL, 1'b1, 1'b1, 1'b0};
            default: ev = '{SIG_SCL, 1'b0, 1'b0, 1'b0};
          endcase
        end else begin
          if (phase_q == 2'd0) ev = '{SIG_SCL, 1'b1, 1'b1, 1'b0};
          else                 ev = '{SIG_SCL, 1'b0, 1'b1, 1'b0};
        end
      end
      ST_POST: begin
        if (cur_q.item.op == OP_WRITE) begin
          unique case (step_q[1:0])
            2'd0:    ev = '{SIG_DIR, 1'b0, 1'b1, 1'b0};
            2'd1:    ev = '{SIG_SCL, 1'b1, 1'b1, 1'b0};
            default: ev = '{SIG_SCL, 1'b0, 1'b1, post_end};
          endcase
        end else begin
          unique case (step_q[1:0])
            2'd0:    ev = '{SIG_DIR, 1'b1, 1'b0, 1'b0};
            2'd1:    ev = '{SIG_SDA, cur_q.item.final_byte, 1'b1, 1'b0};
            2'd2:    ev = '{SIG_SCL, 1'b1, 1'b1, 1'b0};
            default: ev = '{SIG_SCL, 1'b0, 1'b0, post_end};
          endcase
        end
      end
      default: begin
        ev = '{SIG_SCL, scl_q, 1'b0, 1'b0};
      end
    endcase
  end

  // Apply the event to the held pin state and build the result word
  always_comb begin
    scl_d = scl_q;
    sda_d = sda_q;
    drv_d = drv_q;
    unique case (ev.sig)
      SIG_DIR: drv_d = ev.val;
      SIG_SDA: sda_d = ev.val;
      default: scl_d = ev.val;
    endcase
    res_push_o        = fire;
    res_o.station_res = cur_q.item.station;
    res_o.scl_level   = scl_d;
    res_o.sda_level   = sda_d;
    res_o.sda_drive   = drv_d;
    res_o.wait_after  = ev.wait_after;
    res_o.last        = ev.last;
    res_o.read_data   = (ev.last && (cur_q.item.op == OP_READ)) ? cur_q.item.slave_bits : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      bit_q   <= '0;
      phase_q <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      drv_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      bit_q   <= bit_d;
      phase_q <= phase_d;
      if (fire) begin
        scl_q <= scl_d;
        sda_q <= sda_d;
        drv_q <= drv_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= cmd_i;
    end
  end

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && ev.last |=> state_q == ST_IDLE)
    else $error("sequencer kept running after the last word of a command");

  a_loop_has_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOP |-> cur_q.item.op == OP_WRITE || cur_q.item.op == OP_READ)
    else $error("bit loop entered for a command without data bits");

  a_read_data_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !ev.last |-> res_o.read_data == 8'd0)
    else $error("read data shown before the last word");

  a_stop_releases_bus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && ev.last && cur_q.item.op == OP_STOP |=> scl_q && sda_q && drv_q)
    else $error("bus not released after stop");

  a_start_holds_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && ev.last && cur_q.item.op == OP_START |=> !scl_q && !sda_q)
    else $error("lines not low after start");

endmodule

[rtl/i2c_master_pin_sequencer.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Word
// command   in         push_i / full_o      cmd_i (in_t: op, station, byte, final, bits)
// event     out        pop_i / empty_o      res_o (res_t: one pin event)
//
// The sequencer emits one event word per cycle while the event queue has room:
// start 5, stop 6, write 29, read 22 words; idle loads each command from the queue.
// Reset sets SCL and SDA high with SDA driven, and empties both queues.
// A full event queue stalls the sequencer; a full command queue raises full_o.
// Commands keep being accepted while the sequencer works or results wait.

module i2c_master_pin_sequencer
  import i2cps_pkg::*;
#(
  parameter int unsigned CMD_DEPTH = CMD_DEPTH_DEF,
  parameter int unsigned RES_DEPTH = RES_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  in_t  cmd_i,
  output logic empty_o,
  input  logic pop_i,
  output res_t res_o
);

  cmd_t cmd_cls;
  cmd_t cmd_q_data;
  logic cmd_empty;
  logic cmd_pop;
  logic res_full;
  logic res_push;
  res_t res_word;

  i2cps_front u_front (
    .item_i (cmd_i),
    .cmd_o  (cmd_cls)
  );

  i2cps_fifo #(
    .T     (cmd_t),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_cls),
    .full_o  (full_o),
    .pop_i   (cmd_pop),
    .data_o  (cmd_q_data),
    .empty_o (cmd_empty)
  );

  i2cps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_q_data),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_word)
  );

  i2cps_fifo #(
    .T     (res_t),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_word),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (res_o),
    .empty_o (empty_o)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import i2cps_pkg::*;

  typedef enum int {
    RX_FREE,
    RX_RANDOM,
    RX_SLOW,
    RX_PERIODIC
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;
  logic push_i;
  logic full_o;
  in_t  cmd_i;
  logic empty_o;
  logic pop_i = 1'b0;
  res_t res_o;

  // Pin state as the bus master holds it between commands
  logic pin_scl;
  logic pin_sda;
  logic pin_drv;

  res_t     events_due[$];
  int       errors;
  int       burst_left;
  int       words_sent;
  rx_mode_e rx_mode;
  int       rx_left;
  int       rx_phase;

  i2c_master_pin_sequencer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .full_o (full_o),
    .cmd_i  (cmd_i),
    .empty_o(empty_o),
    .pop_i  (pop_i),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Apply one pin change and record the event it produces
  function automatic void emit_pin(ref res_t run[$], input logic [2:0] st, input sig_e sig,
                                   input logic val, input logic hold);
    res_t ev;
    case (sig)
      SIG_DIR: pin_drv = val;
      SIG_SDA: pin_sda = val;
      default: pin_scl = val;
    endcase
    ev.station_res = st;
    ev.scl_level   = pin_scl;
    ev.sda_level   = pin_sda;
    ev.sda_drive   = pin_drv;
    ev.wait_after  = hold;
    ev.read_data   = '0;
    ev.last        = 1'b0;
    run.push_back(ev);
  endfunction

  function automatic void expand_command(input in_t c);
    res_t       run[$];
    logic [2:0] st;
    st = c.station;
    case (c.op)
      OP_START: begin
        emit_pin(run, st, SIG_DIR, 1'b1, 1'b0);
        emit_pin(run, st, SIG_SDA, 1'b1, 1'b0);
        emit_pin(run, st, SIG_SCL, 1'b1, 1'b1);
        emit_pin(run, st, SIG_SDA, 1'b0, 1'b0);
        emit_pin(run, st, SIG_SCL, 1'b0, 1'b0);
      end
      OP_STOP: begin
        emit_pin(run, st, SIG_DIR, 1'b1, 1'b0);
        emit_pin(run, st, SIG_SDA, 1'b0, 1'b0);
        emit_pin(run, st, SIG_SCL, 1'b1, 1'b1);
        emit_pin(run, st, SIG_SDA, 1'b1, 1'b0);
        emit_pin(run, st, SIG_SCL, 1'b0, 1'b1);
        emit_pin(run, st, SIG_SCL, 1'b1, 1'b0);
      end
      OP_WRITE: begin
        emit_pin(run, st, SIG_DIR, 1'b1, 1'b0);
        emit_pin(run, st, SIG_SCL, 1'b0, 1'b0);
        for (int i = 7; i >= 0; i--) begin
          emit_pin(run, st, SIG_SDA, c.data_byte[i], 1'b1);
          emit_pin(run, st, SIG_SCL, 1'b1, 1'b1);
          emit_pin(run, st, SIG_SCL, 1'b0, 1'b0);
        end
        // ack clock with SDA released; the sampled level is dropped
        emit_pin(run, st, SIG_DIR, 1'b0, 1'b1);
        emit_pin(run, st, SIG_SCL, 1'b1, 1'b1);
        emit_pin(run, st, SIG_SCL, 1'b0, 1'b1);
      end
      default: begin
        emit_pin(run, st, SIG_DIR, 1'b0, 1'b0);
        emit_pin(run, st, SIG_SCL, 1'b0, 1'b1);
        for (int i = 0; i < 8; i++) begin
          emit_pin(run, st, SIG_SCL, 1'b1, 1'b1);
          emit_pin(run, st, SIG_SCL, 1'b0, 1'b1);
        end
        emit_pin(run, st, SIG_DIR, 1'b1, 1'b0);
        emit_pin(run, st, SIG_SDA, c.final_byte, 1'b1);
        emit_pin(run, st, SIG_SCL, 1'b1, 1'b1);
        emit_pin(run, st, SIG_SCL, 1'b0, 1'b0);
      end
    endcase
    run[run.size() - 1].last = 1'b1;
    if (c.op == OP_READ) begin
      run[run.size() - 1].read_data = c.slave_bits;
    end
    foreach (run[i]) begin
      events_due.push_back(run[i]);
    end
  endfunction

  // Send one command word; push stays high across back-to-back words in a burst
  task automatic send_word(input in_t w);
    if (burst_left == 0) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    push_i <= 1'b1;
    cmd_i  <= w;
    do @(posedge clk_i); while (full_o);
    expand_command(w);
    burst_left--;
    words_sent++;
  endtask

  task automatic wait_drained();
    push_i <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic in_t make_cmd(input op_e op, input logic [2:0] st);
    in_t c;
    c.op         = op;
    c.station    = st;
    c.data_byte  = 8'($urandom_range(0, 255));
    c.final_byte = 1'($urandom_range(0, 1));
    c.slave_bits = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [2:0] pick_station();
    // mostly real pin pairs, now and then one of the two stations past the last
    if ($urandom_range(0, 9) == 0) begin
      return 3'($urandom_range(6, 7));
    end
    return 3'($urandom_range(0, 5));
  endfunction

  task automatic send_cmd(input op_e op, input logic [2:0] st, input logic [7:0] dbyte,
                          input logic fin, input logic [7:0] sbits);
    in_t c;
    c = make_cmd(op, st);
    c.data_byte  = dbyte;
    c.final_byte = fin;
    c.slave_bits = sbits;
    send_word(c);
  endtask

  task automatic test_directed();
    send_cmd(OP_START, 3'd0, 8'h00, 1'b0, 8'h00);
    send_cmd(OP_WRITE, 3'd0, 8'h00, 1'b0, 8'h00);
    send_cmd(OP_WRITE, 3'd0, 8'hFF, 1'b1, 8'hFF);
    send_cmd(OP_WRITE, 3'd5, 8'hA5, 1'b0, 8'h5A);
    send_cmd(OP_WRITE, 3'd5, 8'h80, 1'b1, 8'h01);
    send_cmd(OP_WRITE, 3'd1, 8'h01, 1'b0, 8'h80);
    send_cmd(OP_READ, 3'd0, 8'hFF, 1'b0, 8'h00);
    send_cmd(OP_READ, 3'd2, 8'h00, 1'b1, 8'hFF);
    send_cmd(OP_READ, 3'd5, 8'h3C, 1'b0, 8'h5A);
    send_cmd(OP_READ, 3'd3, 8'hC3, 1'b1, 8'hA5);
    send_cmd(OP_STOP, 3'd0, 8'hFF, 1'b1, 8'hFF);
    // stations with no pin pair behind them still produce events
    send_cmd(OP_START, 3'd6, 8'h55, 1'b1, 8'hAA);
    send_cmd(OP_WRITE, 3'd7, 8'h6E, 1'b0, 8'h00);
    send_cmd(OP_READ, 3'd7, 8'h00, 1'b1, 8'h81);
    send_cmd(OP_STOP, 3'd6, 8'h00, 1'b0, 8'h00);
    send_cmd(OP_STOP, 3'd7, 8'hAA, 1'b0, 8'h55);
    send_cmd(OP_START, 3'd4, 8'h00, 1'b0, 8'h00);
    send_cmd(OP_START, 3'd4, 8'hFF, 1'b1, 8'hFF);
    send_cmd(OP_READ, 3'd4, 8'h00, 1'b0, 8'h7E);
    send_cmd(OP_STOP, 3'd4, 8'h00, 1'b0, 8'h00);
  endtask

  // Full bus transactions: start, address, data phase, stop
  task automatic test_transactions(input int count);
    logic [2:0] st;
    int         n;
    logic       is_read;
    for (int t = 0; t < count; t++) begin
      st      = pick_station();
      n       = $urandom_range(1, 4);
      is_read = 1'($urandom_range(0, 1));
      send_word(make_cmd(OP_START, st));
      send_word(make_cmd(OP_WRITE, st));
      for (int k = 0; k < n; k++) begin
        in_t c;
        c = make_cmd(is_read ? OP_READ : OP_WRITE, st);
        if (is_read) begin
          c.final_byte = (k == n - 1);
        end
        send_word(c);
      end
      send_word(make_cmd(OP_STOP, st));
    end
  endtask

  // Hold until the block has emptied, then restart from idle
  task automatic test_drained_restart();
    wait_drained();
    send_word(make_cmd(OP_START, 3'd1));
    send_word(make_cmd(OP_READ, 3'd1));
    wait_drained();
    send_word(make_cmd(OP_STOP, 3'd1));
  endtask

  // Commands in any order, including broken sequences
  task automatic test_noise(input int count);
    for (int t = 0; t < count; t++) begin
      send_word(make_cmd(op_e'($urandom_range(0, 3)), 3'($urandom_range(0, 7))));
    end
  endtask

  initial begin
    errors     = 0;
    burst_left = 0;
    words_sent = 0;
    pin_scl    = 1'b1;
    pin_sda    = 1'b1;
    pin_drv    = 1'b1;
    rst_ni     <= 1'b0;
    push_i     <= 1'b0;
    cmd_i      <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_drained_restart();
    while (words_sent < 220) begin
      test_transactions(1);
    end
    test_drained_restart();
    test_noise(40);

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Event checker and receiver stall pattern
  always @(posedge clk_i) begin
    res_t want;
    logic bad;
    if (rst_ni && pop_i && !empty_o) begin
      if (events_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected event word, expected none, got %p", $realtime, res_o);
      end else begin
        want = events_due.pop_front();
        bad  = (res_o.station_res !== want.station_res) |
               (res_o.scl_level !== want.scl_level) |
               (res_o.sda_level !== want.sda_level) |
               (res_o.sda_drive !== want.sda_drive) |
               (res_o.wait_after !== want.wait_after) |
               (res_o.read_data !== want.read_data) |
               (res_o.last !== want.last);
        if (bad) begin
          errors++;
          $display("%0t: event mismatch, expected %p, got %p", $realtime, want, res_o);
        end
      end
    end

    if (rx_left <= 0) begin
      rx_mode  = rx_mode_e'($urandom_range(0, 3));
      rx_left  = $urandom_range(30, 300);
      rx_phase = 0;
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_FREE:     pop_i <= 1'b1;
      RX_RANDOM:   pop_i <= 1'($urandom_range(0, 1));
      RX_SLOW:     pop_i <= ($urandom_range(0, 7) == 0);
      default:     pop_i <= (rx_phase % 3 == 0);
    endcase
  end

endmodule

[sim.f]
rtl/i2cps_pkg.sv
rtl/i2cps_fifo.sv
rtl/i2cps_front.sv
rtl/i2cps_back.sv
rtl/i2c_master_pin_sequencer.sv
tb/tb_top.sv
